// ----- src/pba_pkg.sv -----
// Shared constants and types for the page bitmap allocator.
`timescale 1ns / 1ps
`default_nettype none

package pba_pkg;

    localparam int MAP_BYTES_DEF = 4096;

    localparam int PAGE_W = 20;
    localparam int COUNT_W = 21;
    localparam int BYTES_W = 32;
    localparam int PAGE_SHIFT = 12;

    localparam int WORD_BITS = 32;
    localparam int WORD_SHIFT = 5;

    localparam logic [PAGE_W-1:0] LOW_RESERVED_PAGES = PAGE_W'(256);
    localparam logic [PAGE_W-1:0] TOTAL_PAGES_RESET = PAGE_W'(32768);
    localparam logic [PAGE_W-1:0] KERNEL_END_RESET = PAGE_W'(512);

    localparam logic CFG_TOTAL_PAGES = 1'b0;
    localparam logic CFG_KERNEL_END = 1'b1;

    typedef enum logic [1:0] {
        OP_INIT  = 2'd0,
        OP_ALLOC = 2'd1,
        OP_TEST  = 2'd2,
        OP_MARK  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE   = 2'd0,
        ST_REJECT = 2'd1,
        ST_NO_MEM = 2'd2
    } status_t;

endpackage

`default_nettype wire

// ----- src/page_bitmap_allocator.sv -----
// Top level of the page bitmap allocator: sequencer, bookkeeping and handshakes.
//
// The used map is a RAM of 32-page words, about MAP_BYTES/4 entries. Every
// operation runs alone under one small sequencer; the input channel stalls
// until the result has been handed to the output register, and a new item is
// taken while that result still waits there. Init writes one map word per
// cycle, through the whole map. Test and mark read the page's map word when
// the page is in range and go straight to the response otherwise. An
// allocation reads a whole map word at a time while whole aligned words are
// free or used, and one page per cycle inside a partly used word, from the
// search pointer upward; marking the run then reads and writes each word it
// touches (on the single RAM port pair). Rejected requests go straight to the response.
`timescale 1ns / 1ps
`default_nettype none

module page_bitmap_allocator
    import pba_pkg::*;
#(
    parameter int MAP_BYTES = MAP_BYTES_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    input  wire logic                 cfg_we,
    input  wire logic                 cfg_index,
    input  wire logic [PAGE_W-1:0]    cfg_data,

    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [1:0]           operation,
    input  wire logic [BYTES_W-1:0]   request_bytes,
    input  wire logic [PAGE_W-1:0]    page_index,

    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [1:0]                status,
    output logic [PAGE_W-1:0]         first_page,
    output logic                      page_used,
    output logic [COUNT_W-1:0]        used_pages
);

    localparam int CAP_PAGES = MAP_BYTES * 8;
    localparam int DEPTH = (CAP_PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [COUNT_W-1:0] CAP_C = COUNT_W'(CAP_PAGES);
    localparam logic [AW-1:0] LAST_WORD = AW'(DEPTH - 1);
    localparam logic [COUNT_W-1:0] WORD_PAGES = COUNT_W'(WORD_BITS);
    localparam logic [WORD_BITS-1:0] ONES = '1;

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_INIT     = 9'b000000010,
        S_SCAN_RD  = 9'b000000100,
        S_SCAN     = 9'b000001000,
        S_MARK_RD  = 9'b000010000,
        S_MARK_WR  = 9'b000100000,
        S_PAGE_RD  = 9'b001000000,
        S_PAGE_CHK = 9'b010000000,
        S_RESP     = 9'b100000000
    } state_t;

    // Control state
    state_t               state_reg, state_next;
    logic [PAGE_W-1:0]    total_pages_reg, total_pages_next;
    logic [PAGE_W-1:0]    kernel_end_reg, kernel_end_next;
    logic                 init_done_reg, init_done_next;
    logic [COUNT_W-1:0]   active_reg, active_next;
    logic [COUNT_W-1:0]   search_reg, search_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic                 out_valid_reg, out_valid_next;

    // Working and result payload
    op_t                  op_reg, op_next;
    logic [PAGE_W-1:0]    page_reg, page_next;
    logic [COUNT_W-1:0]   need_reg, need_next;
    logic [COUNT_W-1:0]   ptr_reg, ptr_next;
    logic [COUNT_W-1:0]   run_reg, run_next;
    logic [COUNT_W-1:0]   left_reg, left_next;
    logic [COUNT_W-1:0]   lim_reg, lim_next;
    logic [AW-1:0]        clr_reg, clr_next;
    status_t              res_status_reg, res_status_next;
    logic [PAGE_W-1:0]    res_start_reg, res_start_next;
    logic                 res_used_reg, res_used_next;
    status_t              status_reg, status_next;
    logic [PAGE_W-1:0]    first_page_reg, first_page_next;
    logic                 page_used_reg, page_used_next;
    logic [COUNT_W-1:0]   used_pages_reg, used_pages_next;

    // RAM port
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic                 ram_re;
    logic [AW-1:0]        ram_raddr;
    logic [WORD_BITS-1:0] ram_rdata;

    // Shared datapath terms
    logic                 in_xfer;
    op_t                  in_op;
    logic [COUNT_W-1:0]   page_ext;
    logic [COUNT_W-1:0]   in_need;
    logic [COUNT_W-1:0]   total_ext;
    logic [COUNT_W-1:0]   init_active;
    logic [PAGE_W-1:0]    init_bound;
    logic [COUNT_W-1:0]   init_lim;
    logic [COUNT_W-1:0]   clr_base;
    logic [COUNT_W-1:0]   clr_diff;
    logic [WORD_BITS-1:0] clr_word;
    logic [WORD_SHIFT-1:0] ptr_lo;
    logic                 ptr_bit;
    logic                 word_fits;
    logic [COUNT_W-1:0]   ptr_plus_word;
    logic [COUNT_W-1:0]   run_plus_word;
    logic [COUNT_W-1:0]   run_plus_one;
    logic [WORD_SHIFT:0]  span;
    logic                 mark_last;
    logic [WORD_SHIFT:0]  mark_cnt;
    logic [WORD_SHIFT-1:0] mark_hi;
    logic [WORD_BITS-1:0] mark_mask;
    logic [WORD_SHIFT-1:0] page_lo;
    logic                 page_bit;

    assign in_xfer = in_valid && !in_stall;
    assign in_op = op_t'(operation);
    assign page_ext = {1'b0, page_index};
    assign in_need = {1'b0, request_bytes[BYTES_W-1:PAGE_SHIFT]}
                   + {{(COUNT_W-1){1'b0}}, |request_bytes[PAGE_SHIFT-1:0]};

    assign total_ext = {1'b0, total_pages_reg};
    assign init_active = (total_ext < CAP_C) ? total_ext : CAP_C;
    assign init_bound = (kernel_end_reg < LOW_RESERVED_PAGES) ? LOW_RESERVED_PAGES
                                                              : kernel_end_reg;
    assign init_lim = ({1'b0, init_bound} < init_active) ? {1'b0, init_bound} : init_active;

    // Init word: reserved pages are those below the limit.
    assign clr_base = COUNT_W'({clr_reg, {WORD_SHIFT{1'b0}}});
    assign clr_diff = lim_reg - clr_base;
    always_comb
    begin
        if (lim_reg >= clr_base + WORD_PAGES)
        begin
            clr_word = ONES;
        end
        else if (lim_reg > clr_base)
        begin
            clr_word = ~(ONES << clr_diff[WORD_SHIFT-1:0]);
        end
        else
        begin
            clr_word = '0;
        end
    end

    assign ptr_lo = ptr_reg[WORD_SHIFT-1:0];
    assign ptr_bit = ram_rdata[ptr_lo];
    assign ptr_plus_word = ptr_reg + WORD_PAGES;
    assign run_plus_word = run_reg + WORD_PAGES;
    assign run_plus_one = run_reg + COUNT_W'(1);
    assign word_fits = (ptr_lo == '0) && (ptr_plus_word <= active_reg);

    // Marking covers the run one word at a time, from ptr up to at most the word's end.
    assign span = (WORD_SHIFT+1)'(WORD_BITS) - {1'b0, ptr_lo};
    assign mark_last = left_reg <= COUNT_W'(span);
    assign mark_cnt = mark_last ? left_reg[WORD_SHIFT:0] : span;
    assign mark_hi = WORD_SHIFT'(({1'b0, ptr_lo} + mark_cnt) - (WORD_SHIFT+1)'(1));
    assign mark_mask = (ONES << ptr_lo) & (ONES >> (WORD_SHIFT'(WORD_BITS - 1) - mark_hi));

    assign page_lo = page_reg[WORD_SHIFT-1:0];
    assign page_bit = ram_rdata[page_lo];

    always_comb
    begin
        state_next = state_reg;
        total_pages_next = total_pages_reg;
        kernel_end_next = kernel_end_reg;
        init_done_next = init_done_reg;
        active_next = active_reg;
        search_next = search_reg;
        count_next = count_reg;
        out_valid_next = out_valid_reg;
        op_next = op_reg;
        page_next = page_reg;
        need_next = need_reg;
        ptr_next = ptr_reg;
        run_next = run_reg;
        left_next = left_reg;
        lim_next = lim_reg;
        clr_next = clr_reg;
        res_status_next = res_status_reg;
        res_start_next = res_start_reg;
        res_used_next = res_used_reg;
        status_next = status_reg;
        first_page_next = first_page_reg;
        page_used_next = page_used_reg;
        used_pages_next = used_pages_reg;
        ram_we = 1'b0;
        ram_waddr = ptr_reg[AW+WORD_SHIFT-1:WORD_SHIFT];
        ram_wdata = ram_rdata | mark_mask;
        ram_re = 1'b0;
        ram_raddr = ptr_reg[AW+WORD_SHIFT-1:WORD_SHIFT];

        if (cfg_we)
        begin
            if (cfg_index == CFG_TOTAL_PAGES)
            begin
                total_pages_next = cfg_data;
            end
            else
            begin
                kernel_end_next = cfg_data;
            end
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    op_next = in_op;
                    page_next = page_index;
                    res_status_next = ST_DONE;
                    res_start_next = '0;
                    res_used_next = 1'b0;
                    state_next = S_RESP;
                    unique case (in_op)
                        OP_INIT:
                        begin
                            if (init_done_reg)
                            begin
                                res_status_next = ST_REJECT;
                            end
                            else
                            begin
                                active_next = init_active;
                                lim_next = init_lim;
                                count_next = init_lim;
                                search_next = {1'b0, init_bound};
                                init_done_next = 1'b1;
                                clr_next = '0;
                                state_next = S_INIT;
                            end
                        end
                        OP_ALLOC:
                        begin
                            if (!init_done_reg || request_bytes == '0)
                            begin
                                res_status_next = ST_REJECT;
                            end
                            else
                            begin
                                need_next = in_need;
                                ptr_next = search_reg;
                                run_next = '0;
                                state_next = S_SCAN_RD;
                            end
                        end
                        OP_TEST, OP_MARK:
                        begin
                            if (page_ext < active_reg)
                            begin
                                state_next = S_PAGE_RD;
                            end
                            else if (in_op == OP_TEST)
                            begin
                                res_used_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end

            S_INIT:
            begin
                ram_we = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = clr_word;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == LAST_WORD)
                begin
                    state_next = S_RESP;
                end
            end

            S_SCAN_RD:
            begin
                ram_re = 1'b1;
                state_next = S_SCAN;
            end

            S_SCAN:
            begin
                if (ptr_reg >= active_reg)
                begin
                    res_status_next = ST_NO_MEM;
                    res_start_next = '0;
                    state_next = S_RESP;
                end
                else if (word_fits && ram_rdata == '0 && run_plus_word < need_reg)
                begin
                    // A whole free word that does not yet finish the run.
                    run_next = run_plus_word;
                    ptr_next = ptr_plus_word;
                    state_next = S_SCAN_RD;
                end
                else if ((word_fits && ram_rdata == '0) ||
                         (!ptr_bit && run_plus_one == need_reg))
                begin
                    // The run ends here; it began run pages below the pointer.
                    res_start_next = PAGE_W'(ptr_reg - run_reg);
                    ptr_next = ptr_reg - run_reg;
                    left_next = need_reg;
                    state_next = S_MARK_RD;
                end
                else if (word_fits && ram_rdata == ONES)
                begin
                    run_next = '0;
                    ptr_next = ptr_plus_word;
                    state_next = S_SCAN_RD;
                end
                else
                begin
                    run_next = ptr_bit ? '0 : run_plus_one;
                    ptr_next = ptr_reg + COUNT_W'(1);
                    if (ptr_lo == WORD_SHIFT'(WORD_BITS - 1))
                    begin
                        state_next = S_SCAN_RD;
                    end
                end
            end

            S_MARK_RD:
            begin
                ram_re = 1'b1;
                state_next = S_MARK_WR;
            end

            S_MARK_WR:
            begin
                ram_we = 1'b1;
                ptr_next = ptr_reg + COUNT_W'(mark_cnt);
                left_next = left_reg - COUNT_W'(mark_cnt);
                if (mark_last)
                begin
                    count_next = count_reg + need_reg;
                    search_next = {1'b0, res_start_reg} + need_reg;
                    state_next = S_RESP;
                end
                else
                begin
                    state_next = S_MARK_RD;
                end
            end

            S_PAGE_RD:
            begin
                ram_re = 1'b1;
                ram_raddr = page_reg[AW+WORD_SHIFT-1:WORD_SHIFT];
                state_next = S_PAGE_CHK;
            end

            S_PAGE_CHK:
            begin
                ram_waddr = page_reg[AW+WORD_SHIFT-1:WORD_SHIFT];
                ram_wdata = ram_rdata | (WORD_BITS'(1) << page_lo);
                if (op_reg == OP_TEST)
                begin
                    res_used_next = page_bit;
                end
                else if (!page_bit)
                begin
                    ram_we = 1'b1;
                    count_next = count_reg + COUNT_W'(1);
                end
                state_next = S_RESP;
            end

            S_RESP:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    status_next = res_status_reg;
                    first_page_next = res_start_reg;
                    page_used_next = res_used_reg;
                    used_pages_next = count_reg;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            total_pages_reg <= TOTAL_PAGES_RESET;
            kernel_end_reg <= KERNEL_END_RESET;
            init_done_reg <= 1'b0;
            active_reg <= '0;
            search_reg <= '0;
            count_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            total_pages_reg <= total_pages_next;
            kernel_end_reg <= kernel_end_next;
            init_done_reg <= init_done_next;
            active_reg <= active_next;
            search_reg <= search_next;
            count_reg <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
        page_reg <= page_next;
        need_reg <= need_next;
        ptr_reg <= ptr_next;
        run_reg <= run_next;
        left_reg <= left_next;
        lim_reg <= lim_next;
        clr_reg <= clr_next;
        res_status_reg <= res_status_next;
        res_start_reg <= res_start_next;
        res_used_reg <= res_used_next;
        status_reg <= status_next;
        first_page_reg <= first_page_next;
        page_used_reg <= page_used_next;
        used_pages_reg <= used_pages_next;
    end

    pba_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_stall = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign status = status_reg;
    assign first_page = first_page_reg;
    assign page_used = page_used_reg;
    assign used_pages = used_pages_reg;

endmodule

`default_nettype wire

// ----- src/pba_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module pba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire
